// ===== hw/rtl/smpq_pkg.sv =====
// shared types and constants for the sorted max priority queue
`timescale 1ns / 1ps
package smpq_pkg;

    localparam int DATA_W        = 32;
    localparam int REQ_W         = 2;
    localparam int ST_W          = 2;
    localparam int CNT_OUT_W     = 5;
    localparam int DEFAULT_DEPTH = 16;

    localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_DELETE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_PEEK   = 2'd2;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

    // command broadcast to every cell
    typedef struct packed {
        logic              insert;
        logic              shift_up;
        logic [DATA_W-1:0] value;
    } smpq_cmd_t;

endpackage

// ===== hw/rtl/smpq_req_if.sv =====
// request channel interface
`timescale 1ns / 1ps
interface smpq_req_if
    import smpq_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic [REQ_W-1:0]         req_type;
    logic signed [DATA_W-1:0] new_value;

    modport source (output valid, output req_type, output new_value, input ready);
    modport sink (input valid, input req_type, input new_value, output ready);
endinterface

// ===== hw/rtl/smpq_rsp_if.sv =====
// result channel interface
`timescale 1ns / 1ps
interface smpq_rsp_if
    import smpq_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] result_value;
    logic [ST_W-1:0]          status;
    logic [CNT_OUT_W-1:0]     entry_count;

    modport source (output valid, output result_value, output status,
                    output entry_count, input ready);
    modport sink (input valid, input result_value, input status,
                  input entry_count, output ready);
endinterface

// ===== hw/rtl/sorted_max_priority_queue.sv =====
// top level of the sorted max priority queue
//
//  channel | dir | payload                              | handshake
//  req     | in  | req_type, new_value                  | valid / ready
//  rsp     | out | result_value, status, entry_count    | valid / ready
//
// one request per cycle while no result is stalled; its result is registered and shows in the next cycle
// every cell compares against the new value in the same cycle and shifts
// reset clears the count and the result valid flag; cell contents are not reset
// a stalled result holds req ready low until it is taken
`timescale 1ns / 1ps
module sorted_max_priority_queue
    import smpq_pkg::*;
#(
    parameter int DEPTH = DEFAULT_DEPTH
)
(
    input  logic           clk,
    input  logic           rst_n,
    smpq_req_if.sink       req,
    smpq_rsp_if.source     rsp
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              rsp_valid_reg;
    logic              rsp_valid_next;
    logic [DATA_W-1:0] result_reg;
    logic [DATA_W-1:0] result_next;
    logic [ST_W-1:0]   status_reg;
    logic [ST_W-1:0]   status_next;
    logic [CNT_W-1:0]  rsp_count_reg;

    logic              fire;
    logic              full;
    logic              empty;
    smpq_cmd_t         cmd;

    logic [DATA_W-1:0] cell_value [DEPTH];
    logic              cell_lt    [DEPTH];
    logic              cell_occ   [DEPTH];
    logic              prev_lt    [DEPTH];
    logic [DATA_W-1:0] prev_value [DEPTH];
    logic [DATA_W-1:0] next_value [DEPTH];

    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign fire      = req.valid && req.ready;
    assign full      = (count_reg == CNT_W'(DEPTH));
    assign empty     = (count_reg == '0);

    always_comb
    begin
        cmd.insert   = 1'b0;
        cmd.shift_up = 1'b0;
        cmd.value    = req.new_value;
        result_next  = '0;
        status_next  = ST_OK;
        count_next   = count_reg;
        unique case (req.req_type)
            REQ_INSERT:
            begin
                if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    cmd.insert = fire;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            REQ_DELETE:
            begin
                if (empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    result_next  = cell_value[0];
                    cmd.shift_up = fire;
                    count_next   = count_reg - CNT_W'(1);
                end
            end
            REQ_PEEK:
            begin
                if (empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    result_next = cell_value[0];
                end
            end
            default:
            begin
            end
        endcase
    end

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            assign cell_occ[gi] = (CNT_W'(gi) < count_reg);
            if (gi == 0)
            begin : g_head
                assign prev_lt[gi]    = 1'b0;
                assign prev_value[gi] = cell_value[gi];
            end
            else
            begin : g_body
                assign prev_lt[gi]    = cell_lt[gi-1];
                assign prev_value[gi] = cell_value[gi-1];
            end
            if (gi == DEPTH - 1)
            begin : g_tail
                assign next_value[gi] = cell_value[gi];
            end
            else
            begin : g_link
                assign next_value[gi] = cell_value[gi+1];
            end

            smpq_cell u_cell (
                .clk        (clk),
                .cmd        (cmd),
                .occupied   (cell_occ[gi]),
                .prev_lt    (prev_lt[gi]),
                .prev_value (prev_value[gi]),
                .next_value (next_value[gi]),
                .lt         (cell_lt[gi]),
                .value      (cell_value[gi])
            );
        end
    endgenerate

    always_comb
    begin
        if (fire)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
            if (fire)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            result_reg    <= result_next;
            status_reg    <= status_next;
            rsp_count_reg <= count_next;
        end
    end

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.result_value = result_reg;
    assign rsp.status       = status_reg;
    assign rsp.entry_count  = CNT_OUT_W'(rsp_count_reg);

endmodule

// ===== hw/rtl/smpq_cell.sv =====
// one storage cell of the sorted chain
`timescale 1ns / 1ps
module smpq_cell
    import smpq_pkg::*;
(
    input  logic              clk,
    input  smpq_cmd_t         cmd,
    input  logic              occupied,
    input  logic              prev_lt,
    input  logic [DATA_W-1:0] prev_value,
    input  logic [DATA_W-1:0] next_value,
    output logic              lt,
    output logic [DATA_W-1:0] value
);

    logic [DATA_W-1:0] value_reg;
    logic [DATA_W-1:0] value_next;

    // empty cells count as smaller than anything
    assign lt    = !occupied || ($signed(value_reg) < $signed(cmd.value));
    assign value = value_reg;

    always_comb
    begin
        priority if (cmd.insert && lt)
        begin
            value_next = prev_lt ? prev_value : cmd.value;
        end
        else if (cmd.shift_up)
        begin
            value_next = next_value;
        end
        else
        begin
            value_next = value_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule

// ===== hw/rtl/smpq_checker.sv =====
// port checker for the sorted max priority queue, bound to the top level
`timescale 1ns / 1ps
module smpq_checker
    import smpq_pkg::*;
#(
    parameter int DEPTH = DEFAULT_DEPTH
)
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 req_valid,
    input logic                 req_ready,
    input logic                 rsp_valid,
    input logic                 rsp_ready,
    input logic [DATA_W-1:0]    result_value,
    input logic [ST_W-1:0]      status,
    input logic [CNT_OUT_W-1:0] entry_count
);

    // a stalled result stays offered
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("result dropped while stalled");

    // every accepted request gives a result in the next cycle
    a_req_to_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> rsp_valid)
        else $error("accepted request produced no result");

    // requests are only held off by a waiting result
    a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !req_ready |-> rsp_valid && !rsp_ready)
        else $error("request held off without a stalled result");

    // a refused insert reports a full store
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status == ST_FULL |-> entry_count == CNT_OUT_W'(DEPTH)
            && result_value == '0)
        else $error("full status with wrong count or value");

    // an empty reply reports no entries and no value
    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status == ST_EMPTY |-> entry_count == '0 && result_value == '0)
        else $error("empty status with wrong count or value");

endmodule

bind sorted_max_priority_queue smpq_checker #(.DEPTH(DEPTH)) u_smpq_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (req.valid),
    .req_ready    (req.ready),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .result_value (rsp.result_value),
    .status       (rsp.status),
    .entry_count  (rsp.entry_count)
);

// ===== tb/sv/testbench.sv =====
// self-checking testbench for the sorted max priority queue with a shadow queue
`timescale 1ns / 1ps
module testbench;
    import smpq_pkg::*;

    localparam int DEPTH = DEFAULT_DEPTH;
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
    localparam int CALM_FROM = 800;
    localparam int CALM_TO = 1100;
    localparam int HOLD_AT = 1400;
    localparam int HOLD_CYCLES = 300;

    typedef struct packed {
        logic [REQ_W-1:0]         kind;
        logic signed [DATA_W-1:0] value;
    } pq_request_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic [ST_W-1:0]          status;
        logic [CNT_OUT_W-1:0]     count;
    } pq_reply_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    smpq_req_if req_bus ();
    smpq_rsp_if rsp_bus ();

    sorted_max_priority_queue #(.DEPTH(DEPTH)) DUT
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus.sink),
        .rsp   (rsp_bus.source)
    );

    pq_request_t              pending_reqs[$];
    pq_reply_t                awaited_replies[$];
    logic signed [DATA_W-1:0] shadow_entries[DEPTH];
    int                       shadow_count = 0;

    int sent_count = 0;
    int replies_seen = 0;
    int mismatches = 0;
    int n_stored = 0;
    int n_refused = 0;
    int n_removed = 0;
    int n_peeked = 0;
    int n_empty = 0;
    int n_unused = 0;
    int deepest = 0;
    int hold_left = 0;
    logic hold_done = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // sorted insert, head removal and peek on the shadow copy
    task automatic shadow_apply(input pq_request_t rq);
        pq_reply_t                rp;
        logic signed [DATA_W-1:0] v;
        int                       i;
        v = rq.value;
        rp.value = '0;
        rp.status = ST_OK;
        case (rq.kind)
            REQ_INSERT:
            begin
                if (shadow_count >= DEPTH)
                begin
                    rp.status = ST_FULL;
                    n_refused++;
                end
                else
                begin
                    // equal entries stay ahead of the new value
                    i = shadow_count;
                    while (i > 0 && shadow_entries[i-1] < v)
                    begin
                        shadow_entries[i] = shadow_entries[i-1];
                        i--;
                    end
                    shadow_entries[i] = v;
                    shadow_count++;
                    n_stored++;
                end
            end
            REQ_DELETE, REQ_PEEK:
            begin
                if (shadow_count == 0)
                begin
                    rp.status = ST_EMPTY;
                    n_empty++;
                end
                else
                begin
                    rp.value = shadow_entries[0];
                    if (rq.kind == REQ_DELETE)
                    begin
                        for (i = 0; i < shadow_count - 1; i++)
                            shadow_entries[i] = shadow_entries[i+1];
                        shadow_count--;
                        n_removed++;
                    end
                    else
                        n_peeked++;
                end
            end
            default:
                n_unused++;
        endcase
        if (shadow_count > deepest)
            deepest = shadow_count;
        rp.count = shadow_count[CNT_OUT_W-1:0];
        awaited_replies.push_back(rp);
    endtask

    task automatic add_req(input logic [REQ_W-1:0] kind, input logic [DATA_W-1:0] value);
        pq_request_t rq;
        rq.kind = kind;
        rq.value = value;
        pending_reqs.push_back(rq);
    endtask

    function automatic logic [DATA_W-1:0] pick_value();
        int sel;
        sel = $urandom_range(99);
        if (sel < 60)
            return $urandom;
        else if (sel < 90)
            return 32'($urandom_range(8)) - 32'd4;
        case ($urandom_range(3))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            default: return 32'hffff_ffff;
        endcase
    endfunction

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_bus.valid <= 1'b0;
            req_bus.req_type <= REQ_INSERT;
            req_bus.new_value <= '0;
        end
        else
        begin
            if (req_bus.valid && req_bus.ready)
            begin
                shadow_apply(pending_reqs[0]);
                void'(pending_reqs.pop_front());
                sent_count++;
            end
            if (req_bus.valid && !req_bus.ready)
                ;
            else if (pending_reqs.size() > 0 &&
                     ((sent_count >= CALM_FROM && sent_count < CALM_TO) ||
                      $urandom_range(99) >= 17))
            begin
                req_bus.valid <= 1'b1;
                req_bus.req_type <= pending_reqs[0].kind;
                req_bus.new_value <= pending_reqs[0].value;
            end
            else
                req_bus.valid <= 1'b0;
        end
    end

    // long hold-off on the result side so the request side backs up
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (!hold_done && replies_seen >= HOLD_AT)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin : result_monitor
        pq_reply_t want;
        if (!rst_n)
            rsp_bus.ready <= 1'b0;
        else
        begin
            if (rsp_bus.valid && rsp_bus.ready)
            begin
                replies_seen++;
                if (awaited_replies.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected result value=%0d status=%0d count=%0d", $time,
                             rsp_bus.result_value, rsp_bus.status, rsp_bus.entry_count);
                end
                else
                begin
                    want = awaited_replies.pop_front();
                    if (rsp_bus.result_value !== want.value)
                    begin
                        mismatches++;
                        $display("%0t: result_value expected %0d actual %0d", $time,
                                 want.value, rsp_bus.result_value);
                    end
                    if (rsp_bus.status !== want.status)
                    begin
                        mismatches++;
                        $display("%0t: status expected %0d actual %0d", $time,
                                 want.status, rsp_bus.status);
                    end
                    if (rsp_bus.entry_count !== want.count)
                    begin
                        mismatches++;
                        $display("%0t: entry_count expected %0d actual %0d", $time,
                                 want.count, rsp_bus.entry_count);
                    end
                end
            end
            rsp_bus.ready <= (hold_left == 0) &&
                             ((replies_seen >= CALM_FROM && replies_seen < CALM_TO) ||
                              $urandom_range(99) >= 17);
        end
    end

    initial
    begin : stimulus
        int ph;
        int k;
        int roll;
        int mode;
        logic [REQ_W-1:0] kind;

        // empty queue, unused code, extremes and duplicates
        add_req(REQ_PEEK, 32'h1234_5678);
        add_req(REQ_DELETE, 32'hffff_ffff);
        add_req(REQ_UNUSED, 32'h8000_0000);
        add_req(REQ_INSERT, 32'h7fff_ffff);
        add_req(REQ_INSERT, 32'h8000_0000);
        add_req(REQ_INSERT, 32'h0000_0000);
        add_req(REQ_INSERT, 32'hffff_ffff);
        add_req(REQ_INSERT, 32'h7fff_ffff);
        add_req(REQ_PEEK, 32'h0);
        add_req(REQ_DELETE, 32'h0);
        add_req(REQ_DELETE, 32'h0);
        // fill up, then one refused insert and an unused code on a full queue
        for (k = 0; k < 13; k++)
            add_req(REQ_INSERT, 32'(k % 5) - 32'd2);
        add_req(REQ_INSERT, 32'h7fff_ffff);
        add_req(REQ_UNUSED, 32'h5555_aaaa);

        // phases that fill, mix and drain
        for (ph = 0; ph < 20; ph++)
        begin
            mode = ph % 3;
            for (k = 0; k < 100; k++)
            begin
                roll = $urandom_range(99);
                if (roll < 3)
                    kind = REQ_UNUSED;
                else if (roll < (mode == 0 ? 78 : mode == 1 ? 48 : 23))
                    kind = REQ_INSERT;
                else if (roll < (mode == 0 ? 90 : mode == 1 ? 80 : 83))
                    kind = REQ_DELETE;
                else
                    kind = REQ_PEEK;
                add_req(kind, pick_value());
            end
        end

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (pending_reqs.size() != 0 || req_bus.valid || awaited_replies.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("%0d requests: %0d stored, %0d refused full, %0d removed, %0d peeked",
                 sent_count, n_stored, n_refused, n_removed, n_peeked);
        $display("%0d on an empty queue, %0d unused codes, deepest fill %0d of %0d",
                 n_empty, n_unused, deepest, DEPTH);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("timeout with %0d results outstanding", awaited_replies.size());
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
